/* rtl/i2cag_pkg.sv */
package i2cag_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 11;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_BATCH_COUNT   = 3'd0,
		CFG_CHANNEL_COUNT = 3'd1,
		CFG_INPUT_HEIGHT  = 3'd2,
		CFG_INPUT_WIDTH   = 3'd3,
		CFG_OUTPUT_HEIGHT = 3'd4,
		CFG_OUTPUT_WIDTH  = 3'd5,
		CFG_KERNEL_HEIGHT = 3'd6,
		CFG_KERNEL_WIDTH  = 3'd7
	} cfg_index_t;

	typedef enum logic {
		OP_STEP  = 1'b0,
		OP_START = 1'b1
	} op_t;

	// fixed field widths
	localparam int GEO_W        = 4;
	localparam int BATCH_REG_W  = 5;
	localparam int BATCH_CTR_W  = 4;
	localparam int BATCH_LIMIT  = 16;
	localparam int DIM_REG_W    = 11;
	localparam int KERNEL_REG_W = 4;
	localparam int FIELD_W      = 48;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 96;

	// output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = 3;
	localparam int OCC_W      = 4;
	localparam int FIFO_ENTRY_W = 2 * FIELD_W + 2;

endpackage

/* rtl/im2col_address_generator_core.sv */
// A step item accepted on the slave side passes four multiply/add stages, then an
// eight-entry output queue, before its result shows on the master side.
// Throughput: one item per cycle; the queue credit count lowers s_tready only when
// eight results are in flight or waiting. Start items and idle steps take no credit.
// Reset (arst_n low, asynchronous): job idle, loop counters and geometry cleared,
// queue emptied, all count registers set to one.
module im2col_address_generator_core #(
	parameter int ADDRESS_WIDTH = 48,
	parameter int MAX_DIMENSION = 1024,
	parameter int MAX_KERNEL    = 15
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2cag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// vertical_stride, horizontal_stride, vertical_dilation, horizontal_dilation,
	// vertical_padding, horizontal_padding (4 bits each)
	input  logic [i2cag_pkg::IN_DATA_W-1:0]     s_tdata,
	// operation
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// destination_index [47:0], source_index [95:48]
	output logic [i2cag_pkg::OUT_DATA_W-1:0]    m_tdata,
	// write_enable
	output logic                                m_tuser,
	output logic                                m_tlast
);

	localparam int DIM_MAXREG = (1 << i2cag_pkg::DIM_REG_W) - 1;
	localparam int KER_MAXREG = (1 << i2cag_pkg::KERNEL_REG_W) - 1;
	localparam int DIM_CAP = (MAX_DIMENSION < DIM_MAXREG) ? MAX_DIMENSION : DIM_MAXREG;
	localparam int KER_CAP = (MAX_KERNEL < KER_MAXREG) ? MAX_KERNEL : KER_MAXREG;
	localparam int CW  = $clog2(DIM_CAP);
	localparam int KCW = $clog2(KER_CAP + 1);
	localparam int LW  = ((CW > i2cag_pkg::DIM_REG_W) ? CW : i2cag_pkg::DIM_REG_W) + 1;
	localparam int IXUW = CW + 5;
	localparam int IXW  = CW + 6;
	localparam int CKW  = CW + i2cag_pkg::KERNEL_REG_W;
	localparam int KKW  = KCW + i2cag_pkg::KERNEL_REG_W;
	localparam int OHOW_W = 2 * i2cag_pkg::DIM_REG_W;
	localparam int XOW_W  = CW + i2cag_pkg::DIM_REG_W;
	localparam int BNC_W  = i2cag_pkg::BATCH_CTR_W + i2cag_pkg::DIM_REG_W;
	localparam int RW   = CKW + i2cag_pkg::KERNEL_REG_W + 1;
	localparam int NBW  = i2cag_pkg::BATCH_REG_W + OHOW_W;
	localparam int BOW  = i2cag_pkg::BATCH_CTR_W + OHOW_W;
	localparam int DLW  = XOW_W + 1;
	localparam int SSW  = ((BNC_W > CW) ? BNC_W : CW) + 1;
	localparam int SAW  = SSW + i2cag_pkg::DIM_REG_W + 1;
	localparam int DHW  = RW + NBW;
	localparam int DMW  = ((BOW > DLW) ? BOW : DLW) + 1;
	localparam int SBW  = SAW + i2cag_pkg::DIM_REG_W;
	localparam int DSW  = ((DHW > DMW) ? DHW : DMW) + 1;
	localparam int SSUMW = ((SBW > IXUW) ? SBW : IXUW) + 1;

	// ---------------------------------------------------------------- config
	logic [i2cag_pkg::BATCH_REG_W-1:0]  nb_q;
	logic [i2cag_pkg::DIM_REG_W-1:0]    nc_q, h_q, w_q, oh_q, ow_q;
	logic [i2cag_pkg::KERNEL_REG_W-1:0] kh_q, kw_q;

	function automatic logic [i2cag_pkg::DIM_REG_W-1:0] clamp_dim(
		input logic [i2cag_pkg::DIM_REG_W-1:0] v);
		logic [i2cag_pkg::DIM_REG_W-1:0] r;
		if (v == '0)
			r = i2cag_pkg::DIM_REG_W'(1);
		else if (v > i2cag_pkg::DIM_REG_W'(DIM_CAP))
			r = i2cag_pkg::DIM_REG_W'(DIM_CAP);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [i2cag_pkg::KERNEL_REG_W-1:0] clamp_ker(
		input logic [i2cag_pkg::KERNEL_REG_W-1:0] v);
		logic [i2cag_pkg::KERNEL_REG_W-1:0] r;
		if (v == '0)
			r = i2cag_pkg::KERNEL_REG_W'(1);
		else if (v > i2cag_pkg::KERNEL_REG_W'(KER_CAP))
			r = i2cag_pkg::KERNEL_REG_W'(KER_CAP);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [i2cag_pkg::BATCH_REG_W-1:0] clamp_batch(
		input logic [i2cag_pkg::BATCH_REG_W-1:0] v);
		logic [i2cag_pkg::BATCH_REG_W-1:0] r;
		if (v == '0)
			r = i2cag_pkg::BATCH_REG_W'(1);
		else if (v > i2cag_pkg::BATCH_REG_W'(i2cag_pkg::BATCH_LIMIT))
			r = i2cag_pkg::BATCH_REG_W'(i2cag_pkg::BATCH_LIMIT);
		else
			r = v;
		return r;
	endfunction

	// store counts already clamped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= i2cag_pkg::BATCH_REG_W'(1);
			nc_q <= i2cag_pkg::DIM_REG_W'(1);
			h_q  <= i2cag_pkg::DIM_REG_W'(1);
			w_q  <= i2cag_pkg::DIM_REG_W'(1);
			oh_q <= i2cag_pkg::DIM_REG_W'(1);
			ow_q <= i2cag_pkg::DIM_REG_W'(1);
			kh_q <= i2cag_pkg::KERNEL_REG_W'(1);
			kw_q <= i2cag_pkg::KERNEL_REG_W'(1);
		end else if (cfg_we) begin
			unique case (i2cag_pkg::cfg_index_t'(cfg_index))
				i2cag_pkg::CFG_BATCH_COUNT:
					nb_q <= clamp_batch(cfg_data[i2cag_pkg::BATCH_REG_W-1:0]);
				i2cag_pkg::CFG_CHANNEL_COUNT: nc_q <= clamp_dim(cfg_data);
				i2cag_pkg::CFG_INPUT_HEIGHT:  h_q  <= clamp_dim(cfg_data);
				i2cag_pkg::CFG_INPUT_WIDTH:   w_q  <= clamp_dim(cfg_data);
				i2cag_pkg::CFG_OUTPUT_HEIGHT: oh_q <= clamp_dim(cfg_data);
				i2cag_pkg::CFG_OUTPUT_WIDTH:  ow_q <= clamp_dim(cfg_data);
				i2cag_pkg::CFG_KERNEL_HEIGHT:
					kh_q <= clamp_ker(cfg_data[i2cag_pkg::KERNEL_REG_W-1:0]);
				i2cag_pkg::CFG_KERNEL_WIDTH:
					kw_q <= clamp_ker(cfg_data[i2cag_pkg::KERNEL_REG_W-1:0]);
			endcase
		end
	end

	// ---------------------------------------------------------------- loop nest
	logic                               active_q;
	logic [i2cag_pkg::BATCH_CTR_W-1:0]  b_q;
	logic [CW-1:0]                      c_q, x_q, y_q;
	logic [KCW-1:0]                     kx_q, ky_q;
	logic [i2cag_pkg::GEO_W-1:0]        vs_q, hs_q, vd_q, hd_q, vp_q, hp_q;

	localparam int OCC_W_L = i2cag_pkg::OCC_W;
	logic [OCC_W_L-1:0] occ_q;

	logic acc, start_acc, step_acc, pop;
	logic wr0, wr1, wr2, wr3, wr4, wr5;
	logic [IXUW-1:0] ixu, iyu;
	logic signed [IXW-1:0] ix, iy;

	function automatic logic wraps(input logic [LW-1:0] ctr, input logic [LW-1:0] lim);
		return (ctr + LW'(1)) >= lim;
	endfunction

	assign s_tready  = (occ_q != OCC_W_L'(i2cag_pkg::FIFO_DEPTH));
	assign acc       = s_tvalid && s_tready;
	assign start_acc = acc && (i2cag_pkg::op_t'(s_tuser[0]) == i2cag_pkg::OP_START);
	assign step_acc  = acc && (i2cag_pkg::op_t'(s_tuser[0]) == i2cag_pkg::OP_STEP) && active_q;

	always_comb begin
		wr0 = wraps(LW'(y_q), LW'(ow_q));
		wr1 = wr0 && wraps(LW'(x_q), LW'(oh_q));
		wr2 = wr1 && wraps(LW'(ky_q), LW'(kw_q));
		wr3 = wr2 && wraps(LW'(kx_q), LW'(kh_q));
		wr4 = wr3 && wraps(LW'(c_q), LW'(nc_q));
		wr5 = wr4 && wraps(LW'(b_q), LW'(nb_q));
	end

	// source position of the current step
	always_comb begin
		ixu = IXUW'(vs_q) * IXUW'(x_q) + IXUW'(vd_q) * IXUW'(kx_q);
		iyu = IXUW'(hs_q) * IXUW'(y_q) + IXUW'(hd_q) * IXUW'(ky_q);
		ix  = $signed({1'b0, ixu}) - $signed(IXW'(vp_q));
		iy  = $signed({1'b0, iyu}) - $signed(IXW'(hp_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			b_q  <= '0;
			c_q  <= '0;
			kx_q <= '0;
			ky_q <= '0;
			x_q  <= '0;
			y_q  <= '0;
			vs_q <= '0;
			hs_q <= '0;
			vd_q <= '0;
			hd_q <= '0;
			vp_q <= '0;
			hp_q <= '0;
		end else if (start_acc) begin
			active_q <= 1'b1;
			b_q  <= '0;
			c_q  <= '0;
			kx_q <= '0;
			ky_q <= '0;
			x_q  <= '0;
			y_q  <= '0;
			vs_q <= s_tdata[3:0];
			hs_q <= s_tdata[7:4];
			vd_q <= s_tdata[11:8];
			hd_q <= s_tdata[15:12];
			vp_q <= s_tdata[19:16];
			hp_q <= s_tdata[23:20];
		end else if (step_acc) begin
			// advance innermost first, carry outward on wrap
			y_q <= wr0 ? '0 : y_q + CW'(1);
			if (wr0)
				x_q <= wr1 ? '0 : x_q + CW'(1);
			if (wr1)
				ky_q <= wr2 ? '0 : ky_q + KCW'(1);
			if (wr2)
				kx_q <= wr3 ? '0 : kx_q + KCW'(1);
			if (wr3)
				c_q <= wr4 ? '0 : c_q + CW'(1);
			if (wr4)
				b_q <= wr5 ? '0 : b_q + i2cag_pkg::BATCH_CTR_W'(1);
			if (wr5)
				active_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- pipeline
	logic v_s1, v_s2, v_s3, v_s4;

	logic [i2cag_pkg::BATCH_CTR_W-1:0] b_s1, b_s2;
	logic [CW-1:0]                     c_s1, c_s2, x_s1, y_s1, y_s2;
	logic [KCW-1:0]                    kx_s1, ky_s1, ky_s2;
	logic signed [IXW-1:0]             ix_s1, iy_s1;
	logic                              last_s1, last_s2, last_s3, last_s4;

	logic                              we_s2, we_s3, we_s4;
	logic [CKW-1:0]                    ckh_s2;
	logic [KKW-1:0]                    kxkw_s2;
	logic [OHOW_W-1:0]                 ohow_s2;
	logic [XOW_W-1:0]                  xow_s2;
	logic [BNC_W-1:0]                  bnc_s2;
	logic [IXUW-1:0]                   ix_s2, iy_s2, iy_s3, iy_s4;

	logic [RW-1:0]                     row_s3;
	logic [NBW-1:0]                    nbohow_s3;
	logic [BOW-1:0]                    bohow_s3;
	logic [DLW-1:0]                    dlow_s3;
	logic [SAW-1:0]                    srca_s3;

	logic [DHW-1:0]                    dhi_s4;
	logic [DMW-1:0]                    dmid_s4;
	logic [SBW-1:0]                    srcb_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= step_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		// snapshot of the position being emitted
		b_s1    <= b_q;
		c_s1    <= c_q;
		kx_s1   <= kx_q;
		ky_s1   <= ky_q;
		x_s1    <= x_q;
		y_s1    <= y_q;
		ix_s1   <= ix;
		iy_s1   <= iy;
		last_s1 <= wr5;

		// bounds check and first products
		we_s2   <= !ix_s1[IXW-1] && (ix_s1 < $signed(IXW'(h_q)))
			&& !iy_s1[IXW-1] && (iy_s1 < $signed(IXW'(w_q)));
		ckh_s2  <= CKW'(c_s1) * CKW'(kh_q);
		kxkw_s2 <= KKW'(kx_s1) * KKW'(kw_q);
		ohow_s2 <= OHOW_W'(oh_q) * OHOW_W'(ow_q);
		xow_s2  <= XOW_W'(x_s1) * XOW_W'(ow_q);
		bnc_s2  <= BNC_W'(b_s1) * BNC_W'(nc_q);
		b_s2    <= b_s1;
		c_s2    <= c_s1;
		ky_s2   <= ky_s1;
		y_s2    <= y_s1;
		ix_s2   <= IXUW'(ix_s1);
		iy_s2   <= IXUW'(iy_s1);
		last_s2 <= last_s1;

		// column-matrix row, plane sizes, source row offset
		row_s3    <= RW'(ckh_s2) * RW'(kw_q) + RW'(kxkw_s2) + RW'(ky_s2);
		nbohow_s3 <= NBW'(nb_q) * NBW'(ohow_s2);
		bohow_s3  <= BOW'(b_s2) * BOW'(ohow_s2);
		dlow_s3   <= DLW'(xow_s2) + DLW'(y_s2);
		srca_s3   <= SAW'(SSW'(bnc_s2) + SSW'(c_s2)) * SAW'(h_q) + SAW'(ix_s2);
		iy_s3     <= iy_s2;
		we_s3     <= we_s2;
		last_s3   <= last_s2;

		dhi_s4  <= DHW'(row_s3) * DHW'(nbohow_s3);
		dmid_s4 <= DMW'(bohow_s3) + DMW'(dlow_s3);
		srcb_s4 <= SBW'(srca_s3) * SBW'(w_q);
		iy_s4   <= iy_s3;
		we_s4   <= we_s3;
		last_s4 <= last_s3;
	end

	// ---------------------------------------------------------------- output queue
	logic [DSW-1:0]                  dst_sum;
	logic [SSUMW-1:0]                src_sum;
	logic [i2cag_pkg::FIELD_W-1:0]   dst_f, src_f;
	logic [i2cag_pkg::FIFO_ENTRY_W-1:0] fifo_mem [i2cag_pkg::FIFO_DEPTH];
	logic [i2cag_pkg::FIFO_ENTRY_W-1:0] head;
	logic [i2cag_pkg::FIFO_AW:0]     wr_ptr_q, rd_ptr_q;

	always_comb begin
		dst_sum = DSW'(dhi_s4) + DSW'(dmid_s4);
		src_sum = SSUMW'(srcb_s4) + SSUMW'(iy_s4);
		dst_f   = i2cag_pkg::FIELD_W'(ADDRESS_WIDTH'(dst_sum));
		src_f   = we_s4 ? i2cag_pkg::FIELD_W'(ADDRESS_WIDTH'(src_sum)) : '0;
	end

	always_ff @(posedge clk) begin
		if (v_s4)
			fifo_mem[wr_ptr_q[i2cag_pkg::FIFO_AW-1:0]] <= {last_s4, we_s4, src_f, dst_f};
	end

	assign pop  = m_tvalid && m_tready;
	assign head = fifo_mem[rd_ptr_q[i2cag_pkg::FIFO_AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (v_s4)
				wr_ptr_q <= wr_ptr_q + (i2cag_pkg::FIFO_AW + 1)'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + (i2cag_pkg::FIFO_AW + 1)'(1);
			// credit held from accept until the result is taken
			occ_q <= occ_q + OCC_W_L'(step_acc) - OCC_W_L'(pop);
		end
	end

	assign m_tvalid = (wr_ptr_q != rd_ptr_q);
	assign m_tdata  = head[i2cag_pkg::OUT_DATA_W-1:0];
	assign m_tuser  = head[i2cag_pkg::OUT_DATA_W];
	assign m_tlast  = head[i2cag_pkg::OUT_DATA_W+1];

endmodule

/* rtl/i2cag_checker.sv */
module i2cag_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [i2cag_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic                              m_tuser,
	input logic                              m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// an empty queue shows a result only after an accepted item has passed the pipeline
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 5))
		else $error("result without a matching accepted item");

	// credits run out while results wait in the queue or are still in the pipeline
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// skipped positions carry a zero source index
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[i2cag_pkg::OUT_DATA_W-1:i2cag_pkg::FIELD_W] == '0)
		else $error("source index set on a padded position");

endmodule

bind im2col_address_generator_core i2cag_checker u_i2cag_checker (.*);
